// File: sv/sgvu_pkg.sv
// ============================================================================
// Softened gravity velocity update: shared package
// Types and fixed constants of the velocity update block.
// ============================================================================
`default_nettype none

package sgvu_pkg;

  localparam int VEL_W      = 32;
  localparam int REG_W      = 24;
  localparam int RADIUS_W   = 8;
  localparam int DIST_FRAC  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = REG_W + RADIUS_W;

  localparam logic [REG_W-1:0] GAIN_RESET     = REG_W'(65536);
  localparam logic [REG_W-1:0] MIN_DIST_RESET = REG_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY_GAIN = 2'd0,
    CFG_MIN_DIST_SQ  = 2'd1
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: sv/sgvu_sqrt_pipe.sv
// ============================================================================
// Pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage, with
// a valid bit and a side bus that travel alongside the operand.
// ============================================================================
`default_nettype none

module sgvu_sqrt_pipe #(
  parameter int VW = 42,
  parameter int SW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [VW-1:0]     rad_i,
  input  logic [SW-1:0]     side_i,
  output logic              vld_o,
  output logic [VW/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int RW = VW / 2;
  localparam int MW = RW + 2;

  logic          vld_q  [RW];
  logic [VW-1:0] rad_q  [RW];
  logic [MW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  logic          vld_d  [RW];
  logic [VW-1:0] rad_d  [RW];
  logic [MW-1:0] rem_d  [RW];
  logic [RW-1:0] root_d [RW];
  logic [SW-1:0] side_d [RW];

  always_comb begin : stage_logic
    logic          v;
    logic [VW-1:0] a;
    logic [MW-1:0] r;
    logic [RW-1:0] t;
    logic [SW-1:0] s;
    logic [MW+1:0] trem;
    logic [MW+1:0] trial;
    for (int g = 0; g < RW; g++) begin
      if (g == 0) begin
        v = vld_i;
        a = rad_i;
        r = '0;
        t = '0;
        s = side_i;
      end else begin
        v = vld_q[g-1];
        a = rad_q[g-1];
        r = rem_q[g-1];
        t = root_q[g-1];
        s = side_q[g-1];
      end
      trem  = {r, a[VW-1:VW-2]};
      trial = (MW+2)'({t, 2'b01});
      if (trem >= trial) begin
        rem_d[g]  = MW'(trem - trial);
        root_d[g] = {t[RW-2:0], 1'b1};
      end else begin
        rem_d[g]  = trem[MW-1:0];
        root_d[g] = {t[RW-2:0], 1'b0};
      end
      vld_d[g]  = v;
      rad_d[g]  = {a[VW-3:0], 2'b00};
      side_d[g] = s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < RW; g++) vld_q[g] <= 1'b0;
    end else if (en_i) begin
      for (int g = 0; g < RW; g++) vld_q[g] <= vld_d[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < RW; g++) begin
        rad_q[g]  <= rad_d[g];
        rem_q[g]  <= rem_d[g];
        root_q[g] <= root_d[g];
        side_q[g] <= side_d[g];
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

`default_nettype wire

// File: sv/sgvu_div_pipe.sv
// ============================================================================
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a valid bit
// and a side bus that travel alongside the operands.
// ============================================================================
`default_nettype none

module sgvu_div_pipe #(
  parameter int NW = 60,
  parameter int DW = 41,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  logic          vld_d  [NW];
  logic [NW-1:0] num_d  [NW];
  logic [DW-1:0] rem_d  [NW];
  logic [NW-1:0] quo_d  [NW];
  logic [DW-1:0] den_d  [NW];
  logic [SW-1:0] side_d [NW];

  always_comb begin : stage_logic
    logic          v;
    logic [NW-1:0] n;
    logic [DW-1:0] r;
    logic [NW-1:0] qq;
    logic [DW-1:0] d;
    logic [SW-1:0] s;
    logic [DW:0]   trial;
    for (int g = 0; g < NW; g++) begin
      if (g == 0) begin
        v  = vld_i;
        n  = num_i;
        r  = '0;
        qq = '0;
        d  = den_i;
        s  = side_i;
      end else begin
        v  = vld_q[g-1];
        n  = num_q[g-1];
        r  = rem_q[g-1];
        qq = quo_q[g-1];
        d  = den_q[g-1];
        s  = side_q[g-1];
      end
      trial = {r, n[NW-1]};
      if (trial >= {1'b0, d}) begin
        rem_d[g] = DW'(trial - {1'b0, d});
        quo_d[g] = {qq[NW-2:0], 1'b1};
      end else begin
        rem_d[g] = trial[DW-1:0];
        quo_d[g] = {qq[NW-2:0], 1'b0};
      end
      vld_d[g]  = v;
      num_d[g]  = {n[NW-2:0], 1'b0};
      den_d[g]  = d;
      side_d[g] = s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NW; g++) vld_q[g] <= 1'b0;
    end else if (en_i) begin
      for (int g = 0; g < NW; g++) vld_q[g] <= vld_d[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < NW; g++) begin
        num_q[g]  <= num_d[g];
        rem_q[g]  <= rem_d[g];
        quo_q[g]  <= quo_d[g];
        den_q[g]  <= den_d[g];
        side_q[g] <= side_d[g];
      end
    end
  end

  assign vld_o  = vld_q[NW-1];
  assign quo_o  = quo_q[NW-1];
  assign side_o = side_q[NW-1];

endmodule

`default_nettype wire

// File: sv/softened_gravity_velocity_update_top.sv
// ============================================================================
// Softened gravity velocity update
// Adds the softened gravitational pull of one body on another to the
// attracted body's velocity, with saturation of the result.
// ============================================================================
//
// Channel  Direction  Handshake               Payload
// in       slave      in_valid_i/in_stall_o   positions, velocity, radius
// out      master     out_valid_o/out_stall_i new velocity, clipped flag
// cfg      slave      cfg_valid_i/cfg_ready_o register index, write data
//
// One transaction enters per cycle while no stalled result is held at the
// output. Each passes through the input stages, the bit-per-stage square
// root and the two bit-per-stage dividers to the output register.
// Reset clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// ============================================================================
`default_nettype none

module softened_gravity_velocity_update_top #(
  parameter int FRAC_BITS    = 16,
  parameter int POS_INT_BITS = 12
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [POS_INT_BITS+FRAC_BITS-1:0]        self_pos_x_i,
  input  logic [POS_INT_BITS+FRAC_BITS-1:0]        self_pos_y_i,
  input  logic signed [sgvu_pkg::VEL_W-1:0]        self_vel_x_i,
  input  logic signed [sgvu_pkg::VEL_W-1:0]        self_vel_y_i,
  input  logic [POS_INT_BITS+FRAC_BITS-1:0]        other_pos_x_i,
  input  logic [POS_INT_BITS+FRAC_BITS-1:0]        other_pos_y_i,
  input  logic [sgvu_pkg::RADIUS_W-1:0]            other_radius_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [sgvu_pkg::VEL_W-1:0]        new_vel_x_o,
  output logic signed [sgvu_pkg::VEL_W-1:0]        new_vel_y_o,
  output logic                                     clipped_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [sgvu_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [sgvu_pkg::CFG_DATA_W-1:0]          cfg_data_i
);

  import sgvu_pkg::*;

  localparam int POS_W  = POS_INT_BITS + FRAC_BITS;
  localparam int TW     = POS_INT_BITS + DIST_FRAC;
  localparam int SQW    = 2 * TW;
  localparam int LIMW   = REG_W + 2 * DIST_FRAC;
  localparam int DSW    = (SQW + 1 > LIMW) ? SQW + 1 : LIMW;
  localparam int VW     = DSW + (DSW % 2);
  localparam int RW     = VW / 2;
  localparam int MW     = POS_W + GAIN_W;
  localparam int QW     = MW - 2 * DIST_FRAC;
  localparam int NW2    = QW + DIST_FRAC;
  localparam int SUMW   = ((QW > VEL_W) ? QW : VEL_W) + 2;
  localparam int SIDE0W = DSW + 2 * MW + 2 * VEL_W + 2;
  localparam int SIDEXW = RW + VEL_W + 1;
  localparam int SIDEYW = VEL_W + 1;

  logic adv;

  logic [REG_W-1:0] gain_q, min_dist_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RESET;
      min_dist_q <= MIN_DIST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GRAVITY_GAIN: gain_q     <= cfg_data_i[REG_W-1:0];
        CFG_MIN_DIST_SQ:  min_dist_q <= cfg_data_i[REG_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 1: offsets and their magnitudes.
  logic signed [POS_W:0] dx, dy;
  logic                  v1_q, sx1_q, sy1_q;
  logic [POS_W-1:0]      ax1_q, ay1_q;
  logic [VEL_W-1:0]      vx1_q, vy1_q;
  logic [RADIUS_W-1:0]   rad1_q;

  assign dx = $signed({1'b0, other_pos_x_i}) - $signed({1'b0, self_pos_x_i});
  assign dy = $signed({1'b0, other_pos_y_i}) - $signed({1'b0, self_pos_y_i});

  // Stage 2: squares of the truncated offsets and the scaled mass.
  logic              v2_q, sx2_q, sy2_q;
  logic [POS_W-1:0]  ax2_q, ay2_q;
  logic [VEL_W-1:0]  vx2_q, vy2_q;
  logic [SQW-1:0]    sqx2_q, sqy2_q;
  logic [GAIN_W-1:0] k2_q;
  logic [TW-1:0]     tx, ty;

  assign tx = ax1_q[POS_W-1:FRAC_BITS-DIST_FRAC];
  assign ty = ay1_q[POS_W-1:FRAC_BITS-DIST_FRAC];

  // Stage 3: clamped squared distance and the numerators.
  logic              v3_q, sx3_q, sy3_q;
  logic [VEL_W-1:0]  vx3_q, vy3_q;
  logic [DSW-1:0]    dsq3_q;
  logic [MW-1:0]     px3_q, py3_q;
  logic [DSW-1:0]    dsq_sum, dsq_lim;
  logic [REG_W-1:0]  min_eff;

  assign min_eff = (min_dist_q == '0) ? REG_W'(1) : min_dist_q;
  assign dsq_lim = DSW'({min_eff, {(2 * DIST_FRAC){1'b0}}});
  assign dsq_sum = DSW'({1'b0, sqx2_q} + {1'b0, sqy2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx1_q  <= dx[POS_W];
      sy1_q  <= dy[POS_W];
      ax1_q  <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
      ay1_q  <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
      vx1_q  <= self_vel_x_i;
      vy1_q  <= self_vel_y_i;
      rad1_q <= other_radius_i;

      sx2_q  <= sx1_q;
      sy2_q  <= sy1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      vx2_q  <= vx1_q;
      vy2_q  <= vy1_q;
      sqx2_q <= SQW'(tx) * SQW'(tx);
      sqy2_q <= SQW'(ty) * SQW'(ty);
      k2_q   <= GAIN_W'(gain_q) * GAIN_W'(rad1_q);

      sx3_q  <= sx2_q;
      sy3_q  <= sy2_q;
      vx3_q  <= vx2_q;
      vy3_q  <= vy2_q;
      dsq3_q <= (dsq_sum < dsq_lim) ? dsq_lim : dsq_sum;
      px3_q  <= MW'(ax2_q) * MW'(k2_q);
      py3_q  <= MW'(ay2_q) * MW'(k2_q);
    end
  end

  // Square root of the squared distance.
  logic              vs;
  logic [RW-1:0]     dist_s;
  logic [SIDE0W-1:0] side_s;
  logic [DSW-1:0]    dsq_s;
  logic [MW-1:0]     px_s, py_s;
  logic [VEL_W-1:0]  vx_s, vy_s;
  logic              sx_s, sy_s;

  sgvu_sqrt_pipe #(
    .VW(VW),
    .SW(SIDE0W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (v3_q),
    .rad_i  (VW'(dsq3_q)),
    .side_i ({dsq3_q, px3_q, py3_q, vx3_q, vy3_q, sx3_q, sy3_q}),
    .vld_o  (vs),
    .root_o (dist_s),
    .side_o (side_s)
  );

  assign {dsq_s, px_s, py_s, vx_s, vy_s, sx_s, sy_s} = side_s;

  // First division: offset times mass over squared distance.
  logic              vq_x, vq_y;
  logic [MW-1:0]     q_x, q_y;
  logic [SIDEXW-1:0] sideq_x;
  logic [SIDEYW-1:0] sideq_y;
  logic [RW-1:0]     dist_q;
  logic [VEL_W-1:0]  vxq, vyq;
  logic              sxq, syq;

  sgvu_div_pipe #(
    .NW(MW),
    .DW(DSW),
    .SW(SIDEXW)
  ) u_div1_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vs),
    .num_i  (px_s),
    .den_i  (dsq_s),
    .side_i ({dist_s, vx_s, sx_s}),
    .vld_o  (vq_x),
    .quo_o  (q_x),
    .side_o (sideq_x)
  );

  sgvu_div_pipe #(
    .NW(MW),
    .DW(DSW),
    .SW(SIDEYW)
  ) u_div1_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vs),
    .num_i  (py_s),
    .den_i  (dsq_s),
    .side_i ({vy_s, sy_s}),
    .vld_o  (vq_y),
    .quo_o  (q_y),
    .side_o (sideq_y)
  );

  assign {dist_q, vxq, sxq} = sideq_x;
  assign {vyq, syq}         = sideq_y;

  // Second division: quotient over distance.
  logic              vt_x, vt_y;
  logic [NW2-1:0]    st_x, st_y;
  logic [SIDEYW-1:0] sidet_x, sidet_y;
  logic [VEL_W-1:0]  vxt, vyt;
  logic              sxt, syt;

  sgvu_div_pipe #(
    .NW(NW2),
    .DW(RW),
    .SW(SIDEYW)
  ) u_div2_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vq_x),
    .num_i  ({q_x[QW-1:0], {DIST_FRAC{1'b0}}}),
    .den_i  (dist_q),
    .side_i ({vxq, sxq}),
    .vld_o  (vt_x),
    .quo_o  (st_x),
    .side_o (sidet_x)
  );

  sgvu_div_pipe #(
    .NW(NW2),
    .DW(RW),
    .SW(SIDEYW)
  ) u_div2_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vq_y),
    .num_i  ({q_y[QW-1:0], {DIST_FRAC{1'b0}}}),
    .den_i  (dist_q),
    .side_i ({vyq, syq}),
    .vld_o  (vt_y),
    .quo_o  (st_y),
    .side_o (sidet_y)
  );

  assign {vxt, sxt} = sidet_x;
  assign {vyt, syt} = sidet_y;

  // Output stage: signed update with saturation.
  logic signed [SUMW-1:0] sum_x, sum_y;
  logic                   ovf_x, ovf_y;
  logic [VEL_W-1:0]       sat_x, sat_y;
  logic [VEL_W-1:0]       vel_x_q, vel_y_q;
  logic                   clip_q;

  always_comb begin
    logic signed [SUMW-1:0] vxe, vye, sxe, sye;
    vxe   = $signed({{(SUMW-VEL_W){vxt[VEL_W-1]}}, vxt});
    vye   = $signed({{(SUMW-VEL_W){vyt[VEL_W-1]}}, vyt});
    sxe   = $signed({{(SUMW-QW){1'b0}}, st_x[QW-1:0]});
    sye   = $signed({{(SUMW-QW){1'b0}}, st_y[QW-1:0]});
    sum_x = sxt ? vxe - sxe : vxe + sxe;
    sum_y = syt ? vye - sye : vye + sye;
    ovf_x = (sum_x[SUMW-1:VEL_W-1] != '0) && (sum_x[SUMW-1:VEL_W-1] != '1);
    ovf_y = (sum_y[SUMW-1:VEL_W-1] != '0) && (sum_y[SUMW-1:VEL_W-1] != '1);
    sat_x = !ovf_x ? sum_x[VEL_W-1:0]
          : (sum_x[SUMW-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}});
    sat_y = !ovf_y ? sum_y[VEL_W-1:0]
          : (sum_y[SUMW-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vt_x && vt_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vel_x_q <= sat_x;
      vel_y_q <= sat_y;
      clip_q  <= ovf_x || ovf_y;
    end
  end

  assign out_valid_o = out_vld_q;
  assign new_vel_x_o = vel_x_q;
  assign new_vel_y_o = vel_y_q;
  assign clipped_o   = clip_q;

endmodule

`default_nettype wire

// File: tb/tb.sv
// ============================================================================
// Softened gravity velocity update testbench
// Streams body pairs through the block under random input gaps and output
// stalls, predicts each new velocity or takes it from a table, and compares every result in order.
// ============================================================================
`timescale 1ns / 100ps

module tb;
  import sgvu_pkg::*;

  localparam int POS_W = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX  = 2'd3;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [VEL_W-1:0] VEL_MAX = 32'h7fffffff;
  localparam logic [VEL_W-1:0] VEL_MIN = 32'h80000000;

  typedef struct {
    logic [POS_W-1:0]    sx, sy;
    logic [VEL_W-1:0]    vx, vy;
    logic [POS_W-1:0]    ox, oy;
    logic [RADIUS_W-1:0] radius;
  } pair_t;

  typedef struct {
    logic [VEL_W-1:0] vx, vy;
    logic             clip;
  } velocity_t;

  typedef struct {
    pair_t     pair;
    bit        known;
    velocity_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [POS_W-1:0] self_pos_x_i = '0, self_pos_y_i = '0;
  logic [POS_W-1:0] other_pos_x_i = '0, other_pos_y_i = '0;
  logic signed [VEL_W-1:0] self_vel_x_i = '0, self_vel_y_i = '0;
  logic [RADIUS_W-1:0] other_radius_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [VEL_W-1:0] new_vel_x_o, new_vel_y_o;
  logic clipped_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_GRAVITY_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [REG_W-1:0] gain_reg = GAIN_RESET;
  logic [REG_W-1:0] clamp_reg = MIN_DIST_RESET;
  velocity_t pending_vel[$];
  int errors = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  softened_gravity_velocity_update_top uut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [VEL_W-1:0] pulled_velocity(logic [VEL_W-1:0] vel, bit neg,
      logic [63:0] mag, logic [63:0] k, logic [63:0] dsq, logic [63:0] root_len,
      inout bit clip);
    logic [127:0] q, s;
    logic signed [65:0] nv;
    q = ({64'd0, mag} * {64'd0, k}) / {64'd0, dsq};
    s = (q << DIST_FRAC) / {64'd0, root_len};
    if (s[127:64] != 0) s = {64'd0, {64{1'b1}}};
    nv = neg ? $signed({{34{vel[31]}}, vel}) - $signed({2'b00, s[63:0]})
             : $signed({{34{vel[31]}}, vel}) + $signed({2'b00, s[63:0]});
    if (nv > 66'sd2147483647) begin
      nv = 66'sd2147483647;
      clip = 1;
    end
    if (nv < -66'sd2147483648) begin
      nv = -66'sd2147483648;
      clip = 1;
    end
    return nv[31:0];
  endfunction

  function automatic velocity_t predict_velocity(pair_t p);
    logic signed [30:0] dx, dy;
    logic [63:0] ax, ay, tx, ty, dsq, lim, root_len, k;
    velocity_t r;
    bit clip;
    clip = 0;
    dx = $signed({3'b000, p.ox}) - $signed({3'b000, p.sx});
    dy = $signed({3'b000, p.oy}) - $signed({3'b000, p.sy});
    ax = dx < 0 ? 64'(-dx) : 64'(dx);
    ay = dy < 0 ? 64'(-dy) : 64'(dy);
    tx = ax >> 8;
    ty = ay >> 8;
    dsq = tx * tx + ty * ty;
    lim = 64'(clamp_reg != 0 ? clamp_reg : 24'd1) << (2 * DIST_FRAC);
    if (dsq < lim) dsq = lim;
    root_len = root_floor(dsq);
    k = 64'(gain_reg) * 64'(p.radius);
    r.vx = pulled_velocity(p.vx, dx < 0, ax, k, dsq, root_len, clip);
    r.vy = pulled_velocity(p.vy, dy < 0, ay, k, dsq, root_len, clip);
    r.clip = clip;
    return r;
  endfunction

  task automatic send_pair(pair_t p, bit known, velocity_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    self_pos_x_i = p.sx;
    self_pos_y_i = p.sy;
    self_vel_x_i = p.vx;
    self_vel_y_i = p.vy;
    other_pos_x_i = p.ox;
    other_pos_y_i = p.oy;
    other_radius_i = p.radius;
    do @(posedge clk_i); while (in_stall_o);
    pending_vel.push_back(known ? want : predict_velocity(p));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_GRAVITY_GAIN) gain_reg = data[REG_W-1:0];
    else if (idx == CFG_MIN_DIST_SQ) clamp_reg = data[REG_W-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_vel.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    int spread;
    p.sx = POS_W'($urandom);
    p.sy = POS_W'($urandom);
    case ($urandom_range(3))
      0: spread = 32'h0fffffff;
      1: spread = 32'h0003ffff;
      default: spread = 32'h000fffff;
    endcase
    p.ox = p.sx + POS_W'($urandom_range(spread)) - POS_W'(spread / 2);
    p.oy = p.sy + POS_W'($urandom_range(spread)) - POS_W'(spread / 2);
    case ($urandom_range(5))
      0: p.vx = VEL_MAX - $urandom_range(255);
      1: p.vx = VEL_MIN + $urandom_range(255);
      default: p.vx = $urandom;
    endcase
    case ($urandom_range(5))
      0: p.vy = VEL_MAX - $urandom_range(255);
      1: p.vy = VEL_MIN + $urandom_range(255);
      default: p.vy = $urandom;
    endcase
    p.radius = RADIUS_W'($urandom);
    return p;
  endfunction

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    velocity_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_vel.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h %b",
                                   new_vel_x_o, new_vel_y_o, clipped_o);
      end else begin
        w = pending_vel.pop_front();
        if (new_vel_x_o !== w.vx || new_vel_y_o !== w.vy || clipped_o !== w.clip) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h %h %b, got %h %h %b",
                     w.vx, w.vy, w.clip, new_vel_x_o, new_vel_y_o, clipped_o);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    row_t rows[12];
    velocity_t none;
    pair_t p;
    logic [REG_W-1:0] gains[6];
    logic [CFG_DATA_W-1:0] clamps[6];
    none = '{vx: '0, vy: '0, clip: 1'b0};
    rows = '{
      '{'{'0, '0, '0, '0, '0, '0, '0}, 1, '{'0, '0, 1'b0}},
      '{'{POS_MAX, POS_MAX, VEL_MAX, VEL_MIN, POS_MAX, POS_MAX, 8'hff}, 1,
        '{VEL_MAX, VEL_MIN, 1'b0}},
      '{'{28'h123_4567, 28'h0ab_cdef, 32'h1234_5678, 32'hfedc_ba98,
          28'h0, POS_MAX, 8'h00}, 1, '{32'h1234_5678, 32'hfedc_ba98, 1'b0}},
      '{'{'0, '0, VEL_MAX, VEL_MIN, POS_MAX, POS_MAX, 8'hff}, 0, none},
      '{'{POS_MAX, POS_MAX, VEL_MIN, VEL_MAX, '0, '0, 8'hff}, 0, none},
      '{'{28'h010_0000, 28'h010_0000, VEL_MAX, VEL_MAX,
          28'h010_0100, 28'h010_0100, 8'hff}, 0, none},
      '{'{28'h010_0100, 28'h010_0100, VEL_MIN, VEL_MIN,
          28'h010_0000, 28'h010_0000, 8'hff}, 0, none},
      '{'{28'h080_0000, 28'h080_0000, '0, '0, 28'h081_0000, 28'h080_0000, 8'h01}, 0, none},
      '{'{28'h080_0000, 28'h080_0000, '0, '0, 28'h080_0000, 28'h07f_0000, 8'h80}, 0, none},
      '{'{28'h080_0000, 28'h080_0000, '0, '0, 28'h080_00ff, 28'h080_00ff, 8'hff}, 0, none},
      '{'{28'h000_0001, 28'h000_0000, 32'hffff_ffff, 32'h1, 28'h000_0000,
          28'h000_0001, 8'h7f}, 0, none},
      '{'{28'h555_5555, 28'haaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
          28'haaa_aaaa, 28'h555_5555, 8'h55}, 0, none}
    };
    gains = '{24'h00ffff, 24'hffffff, 24'h000000, 24'h010000, 24'h000001, 24'h3a5c71};
    clamps = '{32'h0000_0001, 32'h0000_0000, 32'h00ff_ffff, 32'hff00_0040,
               32'h0000_0400, 32'h0000_0010};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].want);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_GRAVITY_GAIN, {8'($urandom), gains[ph]});
      write_reg(CFG_MIN_DIST_SQ, clamps[ph]);
      if (ph == 3) write_reg(CFG_UNMAPPED, $urandom);
      if (ph == 4) write_reg(CFG_TOP_IDX, $urandom);
      for (int n = 0; n < 90; n++) begin
        case ((ph * 90 + n) / 30 % 5)
          0: begin send_gap_pct = 0;  stall_pct = 0;  end
          1: begin send_gap_pct = 71; stall_pct = 0;  end
          2: begin send_gap_pct = 0;  stall_pct = 71; end
          3: begin send_gap_pct = 18; stall_pct = 18; end
          default: begin send_gap_pct = 0; stall_pct = 0; end
        endcase
        p = random_pair();
        if (n % 23 == 0) begin
          p.ox = p.sx;
          p.oy = p.sy;
        end
        send_pair(p, 0, none);
      end
      drain();
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sgvu_pkg.sv
sv/sgvu_sqrt_pipe.sv
sv/sgvu_div_pipe.sv
sv/softened_gravity_velocity_update_top.sv
tb/tb.sv
